@@ rtl/assert_macros.svh @@
// Assertion helpers; clk and rst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define MPCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define MPCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mpct_pkg.sv @@
package mpct_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_INDEX_BITS = 2;
    // 9-bit movement, one extra bit so the negated y movement fits
    localparam int DELTA_BITS     = 10;

    localparam int X_LOWEST_RESET  = 0;
    localparam int X_HIGHEST_RESET = 639;
    localparam int Y_LOWEST_RESET  = 0;
    localparam int Y_HIGHEST_RESET = 479;
    localparam int CURSOR_X_RESET  = 320;
    localparam int CURSOR_Y_RESET  = 240;

    // Header byte bit positions
    localparam int HDR_SYNC_BIT   = 3;
    localparam int HDR_X_SIGN_BIT = 4;
    localparam int HDR_Y_SIGN_BIT = 5;
    localparam int BUTTON_BITS    = 3;

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_XMOVE  = 2'd1,
        POS_YMOVE  = 2'd2
    } byte_pos_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_X_LOWEST  = 2'd0,
        REG_X_HIGHEST = 2'd1,
        REG_Y_LOWEST  = 2'd2,
        REG_Y_HIGHEST = 2'd3
    } cfg_index_t;

endpackage

@@ rtl/mpct_axis.sv @@
module mpct_axis #(
    parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]                 cur,
    input  logic signed [mpct_pkg::DELTA_BITS-1:0] delta,
    input  logic [COORD_BITS-1:0]                 lowest,
    input  logic [COORD_BITS-1:0]                 highest,
    output logic [COORD_BITS-1:0]                 result
);
    import mpct_pkg::*;

    localparam int SUM_BITS = COORD_BITS + 2;

    logic signed [SUM_BITS-1:0] sum;
    logic signed [SUM_BITS-1:0] lo_s;
    logic signed [SUM_BITS-1:0] hi_s;
    logic signed [SUM_BITS-1:0] after_lo;
    logic signed [SUM_BITS-1:0] after_hi;

    always_comb
    begin
        sum      = signed'({2'b00, cur}) + SUM_BITS'(delta);
        lo_s     = signed'({2'b00, lowest});
        hi_s     = signed'({2'b00, highest});
        // lowest first, then highest, so highest wins when they cross
        after_lo = (sum < lo_s) ? lo_s : sum;
        after_hi = (after_lo > hi_s) ? hi_s : after_lo;
        result   = after_hi[COORD_BITS-1:0];
    end

endmodule

@@ rtl/mouse_packet_cursor_tracker.sv @@
// Gathers PS/2 mouse bytes into three-byte packets (header, x move, y move) and
// keeps a clamped cursor position and the button states. One result beat comes
// out for every third byte; packet_ok is low when header bit 3 was clear, in
// which case cursor and buttons show their unchanged values. A byte is taken
// every cycle while in_stall is low: it is held in an input register, then the
// add-and-clamp logic writes the cursor and the output register, which raises
// out_valid. in_stall rises only while a finished result waits on out_stall
// and a third byte is ready behind it. Limit registers may be written only
// while no packet is in flight.
module mouse_packet_cursor_tracker #(
    parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [mpct_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [COORD_BITS-1:0]               wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                packet_ok,
    output logic [COORD_BITS-1:0]               cursor_x_out,
    output logic [COORD_BITS-1:0]               cursor_y_out,
    output logic                                left_button,
    output logic                                right_button,
    output logic                                middle_button
);
    import mpct_pkg::*;

    localparam logic [COORD_BITS-1:0] X_LO_RST = COORD_BITS'(X_LOWEST_RESET);
    localparam logic [COORD_BITS-1:0] X_HI_RST = COORD_BITS'(X_HIGHEST_RESET);
    localparam logic [COORD_BITS-1:0] Y_LO_RST = COORD_BITS'(Y_LOWEST_RESET);
    localparam logic [COORD_BITS-1:0] Y_HI_RST = COORD_BITS'(Y_HIGHEST_RESET);
    localparam logic [COORD_BITS-1:0] CX_RST   = COORD_BITS'(CURSOR_X_RESET);
    localparam logic [COORD_BITS-1:0] CY_RST   = COORD_BITS'(CURSOR_Y_RESET);

    logic [COORD_BITS-1:0] x_lowest_reg, x_lowest_next;
    logic [COORD_BITS-1:0] x_highest_reg, x_highest_next;
    logic [COORD_BITS-1:0] y_lowest_reg, y_lowest_next;
    logic [COORD_BITS-1:0] y_highest_reg, y_highest_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic [7:0]            s1_byte_reg, s1_byte_next;
    byte_pos_t             pos_reg, pos_next;
    logic [7:0]            header_reg, header_next;
    logic [7:0]            xmove_reg, xmove_next;
    logic [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [BUTTON_BITS-1:0] buttons_reg, buttons_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  ok_reg, ok_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic [COORD_BITS-1:0] out_y_reg, out_y_next;
    logic [BUTTON_BITS-1:0] out_btn_reg, out_btn_next;

    logic in_accept;
    logic s1_take;
    logic pkt_done;
    logic apply;

    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
    logic signed [DELTA_BITS-1:0] neg_dy;
    logic [COORD_BITS-1:0]        x_new;
    logic [COORD_BITS-1:0]        y_new;

    // A third byte needs room in the output register; the others do not.
    assign s1_take   = s1_valid_reg && ((pos_reg != POS_YMOVE) || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_take;
    assign in_accept = in_valid && !in_stall;
    assign pkt_done  = s1_take && (pos_reg == POS_YMOVE);
    assign apply     = pkt_done && header_reg[HDR_SYNC_BIT];

    assign dx     = signed'({header_reg[HDR_X_SIGN_BIT], header_reg[HDR_X_SIGN_BIT], xmove_reg});
    assign dy     = signed'({header_reg[HDR_Y_SIGN_BIT], header_reg[HDR_Y_SIGN_BIT], s1_byte_reg});
    assign neg_dy = -dy;

    mpct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .cur     (cursor_x_reg),
        .delta   (dx),
        .lowest  (x_lowest_reg),
        .highest (x_highest_reg),
        .result  (x_new)
    );

    // Screen y grows downward: subtract the mouse y movement.
    mpct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .cur     (cursor_y_reg),
        .delta   (neg_dy),
        .lowest  (y_lowest_reg),
        .highest (y_highest_reg),
        .result  (y_new)
    );

    always_comb
    begin
        x_lowest_next  = x_lowest_reg;
        x_highest_next = x_highest_reg;
        y_lowest_next  = y_lowest_reg;
        y_highest_next = y_highest_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_X_LOWEST:  x_lowest_next  = wr_data;
                REG_X_HIGHEST: x_highest_next = wr_data;
                REG_Y_LOWEST:  y_lowest_next  = wr_data;
                REG_Y_HIGHEST: y_highest_next = wr_data;
                default: ;
            endcase
        end
    end

    // Byte position: next state
    always_comb
    begin
        pos_next = pos_reg;
        if (s1_take)
        begin
            unique case (pos_reg)
                POS_HEADER: pos_next = POS_XMOVE;
                POS_XMOVE:  pos_next = POS_YMOVE;
                POS_YMOVE:  pos_next = POS_HEADER;
                default:    pos_next = POS_HEADER;
            endcase
        end
    end

    // Byte position: outputs (packet state and result beat)
    always_comb
    begin
        s1_valid_next = in_accept || (s1_valid_reg && !s1_take);
        s1_byte_next  = in_accept ? rx_byte : s1_byte_reg;

        header_next   = header_reg;
        xmove_next    = xmove_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        buttons_next  = buttons_reg;

        if (s1_take)
        begin
            unique case (pos_reg)
                POS_HEADER: header_next = s1_byte_reg;
                POS_XMOVE:  xmove_next  = s1_byte_reg;
                default: ;
            endcase
        end

        if (apply)
        begin
            cursor_x_next = x_new;
            cursor_y_next = y_new;
            buttons_next  = header_reg[BUTTON_BITS-1:0];
        end

        // Hold the beat while stalled, drop it once taken.
        out_valid_next = pkt_done || (out_valid_reg && out_stall);
        ok_next        = ok_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_btn_next   = out_btn_reg;
        if (pkt_done)
        begin
            ok_next      = apply;
            out_x_next   = cursor_x_next;
            out_y_next   = cursor_y_next;
            out_btn_next = buttons_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lowest_reg  <= X_LO_RST;
            x_highest_reg <= X_HI_RST;
            y_lowest_reg  <= Y_LO_RST;
            y_highest_reg <= Y_HI_RST;
            s1_valid_reg  <= 1'b0;
            pos_reg       <= POS_HEADER;
            header_reg    <= '0;
            xmove_reg     <= '0;
            cursor_x_reg  <= CX_RST;
            cursor_y_reg  <= CY_RST;
            buttons_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_lowest_reg  <= x_lowest_next;
            x_highest_reg <= x_highest_next;
            y_lowest_reg  <= y_lowest_next;
            y_highest_reg <= y_highest_next;
            s1_valid_reg  <= s1_valid_next;
            pos_reg       <= pos_next;
            header_reg    <= header_next;
            xmove_reg     <= xmove_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            buttons_reg   <= buttons_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_byte_reg <= s1_byte_next;
        ok_reg      <= ok_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_btn_reg <= out_btn_next;
    end

    assign out_valid     = out_valid_reg;
    assign packet_ok     = ok_reg;
    assign cursor_x_out  = out_x_reg;
    assign cursor_y_out  = out_y_reg;
    assign left_button   = out_btn_reg[0];
    assign right_button  = out_btn_reg[1];
    assign middle_button = out_btn_reg[2];

endmodule

@@ rtl/mpct_checker.sv @@
`include "assert_macros.svh"

module mpct_checker #(
    parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  packet_ok,
    input logic [COORD_BITS-1:0] cursor_x_out,
    input logic [COORD_BITS-1:0] cursor_y_out,
    input logic                  left_button,
    input logic                  right_button,
    input logic                  middle_button
);
    import mpct_pkg::*;

    localparam int PAYLOAD_BITS = 2 * COORD_BITS + BUTTON_BITS + 1;

    logic                    seen_reg, seen_next;
    logic [COORD_BITS-1:0]   last_x_reg, last_x_next;
    logic [COORD_BITS-1:0]   last_y_reg, last_y_next;
    logic [BUTTON_BITS-1:0]  last_btn_reg, last_btn_next;
    logic [BUTTON_BITS-1:0]  btn;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    out_beat;
    logic                    out_held;
    logic                    drop_shown;
    logic                    same_as_last;

    assign btn          = {middle_button, right_button, left_button};
    assign payload      = {packet_ok, cursor_x_out, cursor_y_out, btn};
    assign out_beat     = out_valid && !out_stall;
    assign out_held     = out_valid && out_stall;
    assign drop_shown   = out_valid && !packet_ok && seen_reg;
    assign same_as_last = (cursor_x_out == last_x_reg) && (cursor_y_out == last_y_reg)
                          && (btn == last_btn_reg);

    always_comb
    begin
        seen_next     = seen_reg || out_beat;
        last_x_next   = out_beat ? cursor_x_out : last_x_reg;
        last_y_next   = out_beat ? cursor_y_out : last_y_reg;
        last_btn_next = out_beat ? btn : last_btn_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            last_btn_reg <= '0;
        end
        else
        begin
            seen_reg     <= seen_next;
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            last_btn_reg <= last_btn_next;
        end
    end

    // Input back-pressure only while a finished beat waits downstream.
    `MPCT_ASSERT(a_stall_only_when_full, in_stall |-> out_held, "in_stall without a waiting beat")

    // A rejected packet leaves cursor and buttons as the previous beat showed.
    `MPCT_ASSERT(a_drop_keeps_state, drop_shown |-> same_as_last, "dropped beat moved cursor")

    `MPCT_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(payload), "stalled beat changed")

endmodule

bind mouse_packet_cursor_tracker mpct_checker #(.COORD_BITS(COORD_BITS)) u_mpct_checker (.*);
